### sv/mpc_pkg.sv
// shared types, constants and helpers for the mate pair coverage classifier
`default_nettype none

package mpc_pkg;

	// store geometry
	localparam int MAX_LEN     = 65536;
	localparam int ADDR_W      = $clog2(MAX_LEN);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int POINT_W     = 16;
	localparam int SUM_W       = ADDR_W + POINT_W;
	localparam int COUNT_LIMIT = 1000;
	localparam int CNT_W       = 10;
	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INSERT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_INSERT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAPQ   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE_SKIP  = 3'd4;
	localparam int CFG_DATA_W = 17;

	// request operation codes
	typedef enum logic [1:0] {
		OP_BEGIN  = 2'd0,
		OP_RECORD = 2'd1,
		OP_FINISH = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	// request fields
	typedef struct packed {
		op_t                op;
		logic [16:0]        seq_length;
		logic [15:0]        read_pos;
		logic [15:0]        mate_pos;
		logic               mate_unmapped;
		logic               mate_same_target;
		logic               mate_target_known;
		logic               first_of_pair;
		logic signed [31:0] insert_size;
		logic [7:0]         map_quality;
		logic [15:0]        query_pos;
	} in_t;

	// result fields
	typedef struct packed {
		logic [9:0] bad_count;
		logic [9:0] window_discontiguous;
		logic [9:0] ok_count;
		logic       in_report_range;
		logic       sequence_skipped;
	} out_t;

	// configuration registers
	typedef struct packed {
		logic [15:0] min_insert;
		logic [15:0] max_insert;
		logic [7:0]  min_mapq;
		logic [16:0] window_len;
		logic [15:0] edge_skip;
	} cfg_t;

	// commands handed from front to back
	typedef enum logic [2:0] {
		CMD_CLEAR,
		CMD_POINT,
		CMD_BAD,
		CMD_OK,
		CMD_FINISH,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		logic [LEN_W-1:0]  len;
		logic              rd_ok;
		logic              inr;
		logic              skip;
	} cmd_t;

	// one word of the count store
	typedef struct packed {
		logic [POINT_W-1:0] point;
		logic [CNT_W-1:0]   ok;
		logic [CNT_W-1:0]   bad;
	} cword_t;

	// clip a window sum to the count limit
	function automatic logic [CNT_W-1:0] clip_count(input logic [SUM_W-1:0] v);
		if (v > SUM_W'(COUNT_LIMIT)) begin
			return CNT_W'(COUNT_LIMIT);
		end
		return v[CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

### sv/mate_pair_coverage_classifier.sv
// top level: configuration registers, front end, command queue and back end
`default_nettype none

// Mate pair coverage classifier for one reference sequence.
// Requests come in on req and are taken at a clock edge with start high and
// busy low. Results (queries only) appear on result for one cycle with done
// high; the receiver cannot hold them off. Configuration is written through
// wr_en / wr_index / wr_data; the user must do so only while idle, as the
// block itself does not enforce it. The front end classifies a request in
// the cycle it is taken and pushes a command into a two-entry queue; busy
// is high while that queue is full. Back end work per command:
//   begin sequence: the counts are zeroed one per cycle over the new length
//   record: one read-modify-write per base over the span (one base for
//   a point record); filtered records leave no command
//   finish: sums the first window, slides it along and copies the edges out
//   query: both stores are read at the position; the result is registered
// Reset clears the queue and the sequence state: the sequence counts as
// skipped, with length zero, until the next begin request.

module mate_pair_coverage_classifier import mpc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output      logic                  busy,
	input  wire in_t                   req,
	output      logic                  done,
	output      out_t                  result,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data
);

	cfg_t cfg_q;
	cmd_t front_cmd;
	logic front_valid;
	cmd_t back_cmd;
	logic q_full;
	logic q_empty;
	logic back_pop;
	logic take;

	assign busy = q_full;
	assign take = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_insert <= 16'd10;
			cfg_q.max_insert <= 16'd5000;
			cfg_q.min_mapq   <= 8'd30;
			cfg_q.window_len <= 17'd1650;
			cfg_q.edge_skip  <= 16'd4000;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_MIN_INSERT: cfg_q.min_insert <= wr_data[15:0];
				CFG_MAX_INSERT: cfg_q.max_insert <= wr_data[15:0];
				CFG_MIN_MAPQ:   cfg_q.min_mapq   <= wr_data[7:0];
				CFG_WINDOW_LEN: cfg_q.window_len <= wr_data;
				CFG_EDGE_SKIP:  cfg_q.edge_skip  <= wr_data[15:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	mpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.req      (req),
		.cfg      (cfg_q),
		.cmd      (front_cmd),
		.cmd_valid(front_valid)
	);

	mpc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take && front_valid),
		.push_data(front_cmd),
		.pop      (back_pop),
		.pop_data (back_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	mpc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (back_cmd),
		.cmd_empty(q_empty),
		.cmd_pop  (back_pop),
		.done     (done),
		.result   (result)
	);

	// results never come in consecutive cycles
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done high in consecutive cycles");

	// a skipped sequence reports nothing
	a_skip_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.sequence_skipped |-> result.bad_count == '0 &&
			result.ok_count == '0 && result.window_discontiguous == '0 &&
			!result.in_report_range)
		else $error("skipped sequence returned data");

	// counts stay at or below the limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.bad_count <= CNT_W'(COUNT_LIMIT) &&
			result.ok_count <= CNT_W'(COUNT_LIMIT) &&
			result.window_discontiguous <= CNT_W'(COUNT_LIMIT))
		else $error("count above limit");

endmodule

`default_nettype wire

### sv/mpc_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module mpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### sv/mpc_front.sv
// front end: takes requests, tracks sequence state and classifies into commands
`default_nettype none

module mpc_front import mpc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic take,
	input  wire in_t  req,
	input  wire cfg_t cfg,
	output      cmd_t cmd,
	output      logic cmd_valid
);

	logic [LEN_W-1:0] len_q;
	logic             skip_q;

	logic [LEN_W-1:0]  len_c;
	logic [LEN_W-1:0]  twice;
	logic [LEN_W-1:0]  bound;
	logic              new_skip;
	logic [31:0]       mag;
	logic              bad;
	logic              pass;
	logic [ADDR_W-1:0] lo;
	logic [ADDR_W-1:0] hi;
	logic [LEN_W-1:0]  hi_ext;
	logic [LEN_W-1:0]  q_plus_edge;

	// length clip and short-sequence test
	always_comb begin
		len_c    = (req.seq_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : req.seq_length;
		twice    = {1'b0, cfg.edge_skip} << 1;
		bound    = (twice < cfg.window_len) ? twice : cfg.window_len;
		new_skip = (len_c <= bound);
	end

	// insert size and mapping quality checks
	always_comb begin
		mag  = req.insert_size[31] ? (~req.insert_size + 32'd1) : req.insert_size;
		bad  = (mag < {16'd0, cfg.min_insert}) || (mag > {16'd0, cfg.max_insert});
		pass = !skip_q && (req.map_quality >= cfg.min_mapq);
	end

	// span bounds clipped to the sequence
	always_comb begin
		lo          = (req.read_pos < req.mate_pos) ? req.read_pos : req.mate_pos;
		hi          = (req.read_pos < req.mate_pos) ? req.mate_pos : req.read_pos;
		hi_ext      = {1'b0, hi};
		if (hi_ext >= len_q) begin
			hi_ext = len_q - LEN_W'(1);
		end
		q_plus_edge = {1'b0, req.query_pos} + {1'b0, cfg.edge_skip};
	end

	// command build
	always_comb begin
		cmd       = '0;
		cmd.kind  = CMD_QUERY;
		cmd.len   = len_q;
		cmd.skip  = skip_q;
		cmd_valid = 1'b0;
		unique case (req.op)
			OP_BEGIN: begin
				cmd.kind  = CMD_CLEAR;
				cmd.len   = len_c;
				cmd_valid = 1'b1;
			end
			OP_RECORD: begin
				if (req.mate_unmapped || (!req.mate_same_target && req.mate_target_known)) begin
					cmd.kind  = CMD_POINT;
					cmd.lo    = req.read_pos;
					cmd.hi    = req.read_pos;
					cmd_valid = pass && ({1'b0, req.read_pos} < len_q);
				end else if (req.mate_same_target && req.first_of_pair) begin
					cmd.kind  = bad ? CMD_BAD : CMD_OK;
					cmd.lo    = lo;
					cmd.hi    = hi_ext[ADDR_W-1:0];
					cmd_valid = pass && (len_q != '0) && ({1'b0, lo} < len_q);
				end
			end
			OP_FINISH: begin
				cmd.kind  = CMD_FINISH;
				cmd_valid = !skip_q && (len_q != '0);
			end
			OP_QUERY: begin
				cmd.kind  = CMD_QUERY;
				cmd.lo    = req.query_pos;
				cmd.rd_ok = !skip_q && ({1'b0, req.query_pos} < len_q);
				cmd.inr   = !skip_q && (req.query_pos >= cfg.edge_skip) && (q_plus_edge < len_q);
				cmd_valid = 1'b1;
			end
			default: cmd_valid = 1'b0;
		endcase
	end

	// current sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			skip_q <= 1'b1;
		end else if (take && req.op == OP_BEGIN) begin
			len_q  <= len_c;
			skip_q <= new_skip;
		end
	end

endmodule

`default_nettype wire

### sv/mpc_queue.sv
// short command queue between front and back
`default_nettype none

module mpc_queue import mpc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	input  wire logic pop,
	output      cmd_t pop_data,
	output      logic full,
	output      logic empty
);

	localparam int QAW = $clog2(QUEUE_DEPTH);

	cmd_t           slot_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full     = (count_q == (QAW+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + (QAW+1)'(push && !full) - (QAW+1)'(pop && !empty);
		end
	end

endmodule

`default_nettype wire

### sv/mpc_back.sv
// back end: executes commands on the count and window stores
`default_nettype none

module mpc_back import mpc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire cmd_t cmd,
	input  wire logic cmd_empty,
	output      logic cmd_pop,
	output      logic done,
	output      out_t result
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RMW,
		ST_RMW_END,
		ST_F_INIT,
		ST_F_SUM,
		ST_F_SUMW,
		ST_F_HEAD,
		ST_SL_ADD,
		ST_SL_SUB,
		ST_SL_LAND,
		ST_SL_WR,
		ST_FILL_LO,
		ST_FILL_HI,
		ST_Q_RD,
		ST_Q_OUT
	} state_t;

	state_t            state_q;
	cmd_kind_t         kind_q;
	logic [ADDR_W-1:0] lo_q;
	logic [ADDR_W-1:0] hi_q;
	logic [LEN_W-1:0]  len_q;
	logic              rd_ok_q;
	logic              inr_q;
	logic              skip_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  j_q;
	logic [LEN_W-1:0]  w_q;
	logic [LEN_W-1:0]  h_q;
	logic [LEN_W-1:0]  last_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  first_q;
	logic              wvalid_q;
	logic              acc_s1;
	logic              rmw_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              done_q;
	out_t              result_q;

	logic              c_we;
	logic [ADDR_W-1:0] c_waddr;
	cword_t            c_wdata;
	logic [ADDR_W-1:0] c_raddr;
	cword_t            c_rdata;
	logic              w_we;
	logic [ADDR_W-1:0] w_waddr;
	logic [CNT_W-1:0]  w_wdata;
	logic [CNT_W-1:0]  w_rdata;
	logic [LEN_W-1:0]  wl_eff;
	logic [LEN_W-1:0]  add_addr;
	logic [LEN_W-1:0]  sub_addr;
	logic [LEN_W-1:0]  slide_pos;

	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty;
	assign done    = done_q;
	assign result  = result_q;

	assign wl_eff    = (cfg.window_len == '0) ? LEN_W'(1) : cfg.window_len;
	assign add_addr  = j_q + w_q - LEN_W'(1);
	assign sub_addr  = j_q - LEN_W'(1);
	assign slide_pos = h_q + j_q;

	// count store port control
	always_comb begin
		c_we    = 1'b0;
		c_waddr = cnt_q[ADDR_W-1:0];
		c_wdata = c_rdata;
		c_raddr = cnt_q[ADDR_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				c_we    = (cnt_q != len_q);
				c_wdata = '0;
			end
			ST_RMW, ST_RMW_END: begin
				c_we    = rmw_s1;
				c_waddr = addr_s1;
				unique case (kind_q)
					CMD_POINT: begin
						if (c_rdata.point != '1) begin
							c_wdata.point = c_rdata.point + POINT_W'(1);
						end
					end
					CMD_BAD: begin
						if (c_rdata.bad < CNT_W'(COUNT_LIMIT)) begin
							c_wdata.bad = c_rdata.bad + CNT_W'(1);
						end
					end
					CMD_OK: begin
						if (c_rdata.ok < CNT_W'(COUNT_LIMIT)) begin
							c_wdata.ok = c_rdata.ok + CNT_W'(1);
						end
					end
					default: c_we = 1'b0;
				endcase
			end
			ST_SL_ADD: c_raddr = add_addr[ADDR_W-1:0];
			ST_SL_SUB: c_raddr = sub_addr[ADDR_W-1:0];
			ST_Q_RD:   c_raddr = lo_q;
			default:   c_we    = 1'b0;
		endcase
	end

	// window store port control
	always_comb begin
		w_we    = 1'b0;
		w_waddr = cnt_q[ADDR_W-1:0];
		w_wdata = clip_count(sum_q);
		unique case (state_q)
			ST_F_HEAD: begin
				w_we    = 1'b1;
				w_waddr = h_q[ADDR_W-1:0];
			end
			ST_SL_WR: begin
				w_we    = 1'b1;
				w_waddr = slide_pos[ADDR_W-1:0];
			end
			ST_FILL_LO: begin
				w_we    = (cnt_q != h_q);
				w_wdata = first_q;
			end
			ST_FILL_HI: w_we = (cnt_q != len_q);
			default:    w_we = 1'b0;
		endcase
	end

	mpc_ram #(
		.WIDTH($bits(cword_t)),
		.DEPTH(MAX_LEN)
	) u_count_ram (
		.clk  (clk),
		.we   (c_we),
		.waddr(c_waddr),
		.wdata(c_wdata),
		.raddr(c_raddr),
		.rdata(c_rdata)
	);

	mpc_ram #(
		.WIDTH(CNT_W),
		.DEPTH(MAX_LEN)
	) u_window_ram (
		.clk  (clk),
		.we   (w_we),
		.waddr(w_waddr),
		.wdata(w_wdata),
		.raddr(lo_q),
		.rdata(w_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wvalid_q <= 1'b0;
			acc_s1   <= 1'b0;
			rmw_s1   <= 1'b0;
			done_q   <= 1'b0;
			kind_q   <= CMD_QUERY;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						kind_q  <= cmd.kind;
						lo_q    <= cmd.lo;
						hi_q    <= cmd.hi;
						len_q   <= cmd.len;
						rd_ok_q <= cmd.rd_ok;
						inr_q   <= cmd.inr;
						skip_q  <= cmd.skip;
						cnt_q   <= '0;
						unique case (cmd.kind)
							CMD_CLEAR: begin
								wvalid_q <= 1'b0;
								state_q  <= ST_CLEAR;
							end
							CMD_POINT, CMD_BAD, CMD_OK: begin
								cnt_q   <= {1'b0, cmd.lo};
								state_q <= ST_RMW;
							end
							CMD_FINISH: begin
								w_q     <= (wl_eff < cmd.len) ? wl_eff : cmd.len;
								state_q <= ST_F_INIT;
							end
							default: state_q <= ST_Q_RD;
						endcase
					end
				end
				// zero the counts over the new length
				ST_CLEAR: begin
					if (cnt_q == len_q) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + LEN_W'(1);
					end
				end
				// read-modify-write over the span
				ST_RMW: begin
					rmw_s1  <= 1'b1;
					addr_s1 <= cnt_q[ADDR_W-1:0];
					if (cnt_q[ADDR_W-1:0] == hi_q) begin
						state_q <= ST_RMW_END;
					end else begin
						cnt_q <= cnt_q + LEN_W'(1);
					end
				end
				ST_RMW_END: begin
					rmw_s1  <= 1'b0;
					state_q <= ST_IDLE;
				end
				// window geometry
				ST_F_INIT: begin
					h_q     <= w_q >> 1;
					last_q  <= len_q - w_q + (w_q >> 1);
					cnt_q   <= '0;
					sum_q   <= '0;
					acc_s1  <= 1'b0;
					state_q <= ST_F_SUM;
				end
				// first window sum
				ST_F_SUM: begin
					acc_s1 <= 1'b1;
					if (acc_s1) begin
						sum_q <= sum_q + SUM_W'(c_rdata.point);
					end
					if (cnt_q == w_q - LEN_W'(1)) begin
						state_q <= ST_F_SUMW;
					end else begin
						cnt_q <= cnt_q + LEN_W'(1);
					end
				end
				ST_F_SUMW: begin
					sum_q   <= sum_q + SUM_W'(c_rdata.point);
					acc_s1  <= 1'b0;
					state_q <= ST_F_HEAD;
				end
				ST_F_HEAD: begin
					first_q <= clip_count(sum_q);
					cnt_q   <= '0;
					if (last_q == h_q) begin
						state_q <= ST_FILL_LO;
					end else begin
						j_q     <= LEN_W'(1);
						state_q <= ST_SL_ADD;
					end
				end
				// sliding window: add entering, drop leaving
				ST_SL_ADD: state_q <= ST_SL_SUB;
				ST_SL_SUB: begin
					sum_q   <= sum_q + SUM_W'(c_rdata.point);
					state_q <= ST_SL_LAND;
				end
				ST_SL_LAND: begin
					sum_q   <= sum_q - SUM_W'(c_rdata.point);
					state_q <= ST_SL_WR;
				end
				ST_SL_WR: begin
					if (slide_pos == last_q) begin
						cnt_q   <= '0;
						state_q <= ST_FILL_LO;
					end else begin
						j_q     <= j_q + LEN_W'(1);
						state_q <= ST_SL_ADD;
					end
				end
				// copy the edge values outward
				ST_FILL_LO: begin
					if (cnt_q == h_q) begin
						cnt_q   <= last_q + LEN_W'(1);
						state_q <= ST_FILL_HI;
					end else begin
						cnt_q <= cnt_q + LEN_W'(1);
					end
				end
				ST_FILL_HI: begin
					if (cnt_q == len_q) begin
						wvalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + LEN_W'(1);
					end
				end
				// position readout
				ST_Q_RD: state_q <= ST_Q_OUT;
				ST_Q_OUT: begin
					done_q                          <= 1'b1;
					result_q.bad_count              <= rd_ok_q ? c_rdata.bad : '0;
					result_q.ok_count               <= rd_ok_q ? c_rdata.ok : '0;
					result_q.window_discontiguous   <= (rd_ok_q && wvalid_q) ? w_rdata : '0;
					result_q.in_report_range        <= inr_q;
					result_q.sequence_skipped       <= skip_q;
					state_q                         <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
